/* src/conv3x3_pkg.sv */
// Package for the 3x3 image filter: sizes, register indexes, filter modes and
// the position record passed from the counters to the datapath. No dependencies.
package conv3x3_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int WID_W    = COL_W + 1;
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int HGT_W    = ROW_W + 1;
   localparam int IN_ROW_W = 16;
   localparam logic [IN_ROW_W-1:0] IN_ROW_SAT = '1;

   localparam int MODE_REG_W   = 3;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_W        = 13;

   localparam int CH_W  = 8;
   localparam int PIX_W = 3 * CH_W;
   localparam int SUM_W = 14;

   // (2s+9)/18 as a reciprocal multiply: 7282 = ceil(2^17/18), exact for 2s+9 < 8192
   localparam int BOX_X_W   = 13;
   localparam int BOX_SHIFT = 17;
   localparam int BOX_P_W   = 2 * BOX_X_W;
   localparam logic [BOX_X_W-1:0] BOX_MUL = 13'd7282;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef enum logic [MODE_REG_W-1:0] {
      MODE_BOX     = 3'd0,
      MODE_GAUSS   = 3'd1,
      MODE_OUTLINE = 3'd2,
      MODE_EMBOSS  = 3'd3,
      MODE_SHARPEN = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             take;
      logic             emit;
      logic             last;
      logic             top_ok;
      logic             bot_ok;
      logic             left_ok;
      logic             right_ok;
      logic [COL_W-1:0] col;
   } pos_type;

endpackage

/* src/conv3x3_if.sv */
// Handshake interfaces for the pixel input and filtered pixel output items.
// No dependencies.
interface conv3x3_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface conv3x3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

/* src/conv3x3_image_filter.sv */
// Top level of the streaming 3x3 RGB image filter: registers, input stage,
// window and result register. Uses conv3x3_pkg, conv3x3_if and the submodules.
//
// Pixels enter on req in raster order (kind 0 = pixel, kind 1 = flush tick);
// filtered pixels leave on rsp in raster order, frame_end on the last one.
// Every item advances the input position by one; once the input has passed
// one row plus one pixel of the frame, each item yields one result, so
// image_width + 1 flush items drain the end of a frame.
// One item per clock is sustained while rsp does not stall. An item is held in the
// input stage (line buffer read), then the window update and the nine-tap sum
// load the result register, which drives rsp.valid.
// When rsp stalls, the result register holds and the input stage keeps one
// further item; if that item is due a result, req.ready drops until rsp.ready
// returns (req.ready is high whenever rsp.ready is).
// csr_write_en with csr_index 0/1/2 writes filter_mode, image_width and
// image_height; write them only while the block is idle.
// Reset clears the counters, window and handshake state and loads the default
// registers; the line buffers are not cleared and need no clearing pass.
module conv3x3_image_filter (
   input  logic                              clock,
   input  logic                              reset,
   conv3x3_req_if.sink                       req,
   conv3x3_rsp_if.source                     rsp,
   input  logic                              csr_write_en,
   input  logic [conv3x3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [conv3x3_pkg::CSR_W-1:0]     csr_wdata
);
   import conv3x3_pkg::*;

   logic [MODE_REG_W-1:0]   mode_ff;
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [WID_W-1:0]        width_eff;
   logic [HGT_W-1:0]        height_eff;

   pos_type                 pos;
   pos_type                 a_pos_ff;
   pixel_type               a_pix_ff;
   logic                    a_valid_ff;
   logic                    accept, adv, out_free;

   logic [2*PIX_W-1:0]      lb_rd, lb_wr;
   pixel_type               top, mid;

   pixel_type               win_ff [3][3];
   pixel_type               win_in [3][3];
   logic [8:0]              tap_ok;
   logic [CH_W-1:0]         value [3];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]         res_ff [3];
   logic                    frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_REG_W'(MODE_BOX);
         width_ff  <= WIDTH_REG_W'(2048);
         height_ff <= HEIGHT_REG_W'(4096);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FILTER_MODE:  mode_ff   <= csr_wdata[MODE_REG_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         width_eff = WID_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WID_W'(MAX_WIDTH);
      end else begin
         width_eff = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_eff = HGT_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HGT_W'(MAX_HEIGHT);
      end else begin
         height_eff = HGT_W'(height_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign adv       = a_valid_ff && (!a_pos_ff.emit || out_free);
   assign req.ready = !a_valid_ff || adv;
   assign accept    = req.valid && req.ready;

   conv3x3_position u_position (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .kind   (req.kind),
      .width  (width_eff),
      .height (height_eff),
      .pos    (pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pos_ff <= pos;
         a_pix_ff <= pos.take ? {req.red_in, req.green_in, req.blue_in} : '0;
      end
   end

   assign top   = lb_rd[2*PIX_W-1:PIX_W];
   assign mid   = lb_rd[PIX_W-1:0];
   assign lb_wr = {mid, a_pix_ff};

   conv3x3_linebuf u_linebuf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (lb_rd),
      .wr_en   (adv),
      .wr_addr (a_pos_ff.col),
      .wr_data (lb_wr)
   );

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = top;
      win_in[1][2] = mid;
      win_in[2][2] = a_pix_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            tap_ok[r*3+c] = (r != 0 || a_pos_ff.top_ok) && (r != 2 || a_pos_ff.bot_ok) &&
                            (c != 0 || a_pos_ff.left_ok) && (c != 2 || a_pos_ff.right_ok);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (adv) begin
         win_ff <= win_in;
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [8:0][CH_W-1:0] taps;
      always_comb begin
         for (int i = 0; i < 9; i++) begin
            taps[i] = win_in[i/3][i%3][PIX_W-1-CH_W*ch -: CH_W];
         end
      end
      conv3x3_kernel u_kernel (
         .tap    (taps),
         .tap_ok (tap_ok),
         .mode   (mode_type'(mode_ff)),
         .value  (value[ch])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv && a_pos_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && a_pos_ff.emit) begin
         res_ff       <= value;
         frame_end_ff <= a_pos_ff.last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.red_out   = res_ff[0];
   assign rsp.green_out = res_ff[1];
   assign rsp.blue_out  = res_ff[2];
   assign rsp.frame_end = frame_end_ff;

endmodule

/* src/conv3x3_position.sv */
// Input and output raster counters of the 3x3 filter; decides per item whether
// a result is due and which taps lie inside the frame. Uses conv3x3_pkg.
module conv3x3_position (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          kind,
   input  logic [conv3x3_pkg::WID_W-1:0] width,
   input  logic [conv3x3_pkg::HGT_W-1:0] height,
   output conv3x3_pkg::pos_type          pos
);
   import conv3x3_pkg::*;

   logic [COL_W-1:0]    in_col_ff,  in_col_in;
   logic [IN_ROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [ROW_W-1:0]    out_row_ff, out_row_in;
   logic                in_col_end, out_col_end, out_row_end;

   always_comb begin
      in_col_end  = ({1'b0, in_col_ff} + WID_W'(1)) >= width;
      out_col_end = ({1'b0, out_col_ff} + WID_W'(1)) >= width;
      out_row_end = ({1'b0, out_row_ff} + HGT_W'(1)) >= height;

      pos.take     = !kind && (32'(in_row_ff) < 32'(height));
      pos.emit     = (in_row_ff >= IN_ROW_W'(2)) ||
                     ((in_row_ff == IN_ROW_W'(1)) && (in_col_ff != '0));
      pos.last     = out_row_end && out_col_end;
      pos.top_ok   = out_row_ff != '0;
      pos.bot_ok   = !out_row_end;
      pos.left_ok  = out_col_ff != '0;
      pos.right_ok = !out_col_end;
      pos.col      = in_col_ff;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (pos.emit) begin
         if (out_col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
      if (pos.emit && pos.last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (in_col_end) begin
         in_col_in = '0;
         if (in_row_ff != IN_ROW_SAT) begin
            in_row_in = in_row_ff + IN_ROW_W'(1);
         end
      end else begin
         in_col_in = in_col_ff + COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (step) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

/* src/conv3x3_linebuf.sv */
// Two line buffers of the 3x3 filter held as one memory of {upper, middle}
// entries, with a bypass for a write and read of the same column. Uses conv3x3_pkg.
module conv3x3_linebuf (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [conv3x3_pkg::COL_W-1:0] rd_addr,
   output logic [2*conv3x3_pkg::PIX_W-1:0] rd_data,
   input  logic                          wr_en,
   input  logic [conv3x3_pkg::COL_W-1:0] wr_addr,
   input  logic [2*conv3x3_pkg::PIX_W-1:0] wr_data
);
   import conv3x3_pkg::*;

   logic [2*PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/conv3x3_kernel.sv */
// One colour channel of the 3x3 filter: weighted sum of the nine taps for the
// selected kernel, rounding and clamping to 0..255. Uses conv3x3_pkg.
module conv3x3_kernel (
   input  logic [8:0][conv3x3_pkg::CH_W-1:0] tap,
   input  logic [8:0]                        tap_ok,
   input  conv3x3_pkg::mode_type             mode,
   output logic [conv3x3_pkg::CH_W-1:0]      value
);
   import conv3x3_pkg::*;

   logic [CH_W-1:0]         t [9];
   logic [CH_W+1:0]         corners, edges;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] v;
   logic [BOX_X_W-1:0]      box_x;
   logic [BOX_P_W-1:0]      box_p;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         t[i] = tap_ok[i] ? tap[i] : '0;
      end
      corners = (CH_W+2)'(t[0]) + (CH_W+2)'(t[2]) + (CH_W+2)'(t[6]) + (CH_W+2)'(t[8]);
      edges   = (CH_W+2)'(t[1]) + (CH_W+2)'(t[3]) + (CH_W+2)'(t[5]) + (CH_W+2)'(t[7]);

      case (mode)
         MODE_GAUSS:   sum = SUM_W'(corners) + SUM_W'({edges, 1'b0}) + SUM_W'({t[4], 2'b00});
         MODE_OUTLINE: sum = SUM_W'({t[4], 3'b000}) - SUM_W'(corners) - SUM_W'(edges);
         MODE_EMBOSS:  sum = SUM_W'({t[8], 1'b0}) - SUM_W'({t[0], 1'b0}) + SUM_W'(t[5])
                             + SUM_W'(t[7]) - SUM_W'(t[1]) - SUM_W'(t[3]) + SUM_W'(t[4]);
         MODE_SHARPEN: sum = SUM_W'({t[4], 2'b00}) + SUM_W'(t[4]) - SUM_W'(edges);
         default:      sum = SUM_W'(corners) + SUM_W'(edges) + SUM_W'(t[4]);
      endcase

      // box sum is never negative and below 2^12
      box_x = {sum[BOX_X_W-2:0], 1'b0} + BOX_X_W'(9);
      box_p = BOX_P_W'(box_x) * BOX_P_W'(BOX_MUL);

      case (mode)
         MODE_GAUSS:                           v = (sum + SUM_W'(8)) >>> 4;
         MODE_OUTLINE, MODE_EMBOSS, MODE_SHARPEN: v = sum;
         default:                              v = SUM_W'(box_p >> BOX_SHIFT);
      endcase

      if (v < 0) begin
         value = '0;
      end else if (v > SUM_W'(255)) begin
         value = '1;
      end else begin
         value = v[CH_W-1:0];
      end
   end

endmodule

/* src/conv3x3_checker.sv */
// Port-level assertions for the 3x3 image filter, bound to the top level.
// Depends on conv3x3_image_filter.
module conv3x3_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_frame_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_red, rsp_green, rsp_blue, rsp_frame_end}))
      else $error("result item changed while stalled");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without an item two cycles earlier");

endmodule

bind conv3x3_image_filter conv3x3_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_red       (rsp.red_out),
   .rsp_green     (rsp.green_out),
   .rsp_blue      (rsp.blue_out),
   .rsp_frame_end (rsp.frame_end)
);
